@@ rtl/escd_pkg.sv @@
// Shared types, constants and small tables for the epoch-to-calendar converter.
// Used by escd_ctrl, escd_dp and the top level epoch_seconds_to_calendar_date.
package escd_pkg;

	localparam int unsigned SecsPerDay = 86400;
	localparam int unsigned SecsPerHour = 3600;
	localparam int unsigned YearBias = 400;

	// Day split: 86400 = 2^7 * 675, and x / 675 = (x * 101806633) >> 36 for x below 2^26.
	localparam int unsigned DayOdd = 675;
	localparam int unsigned Recip675 = 101806633;

	// Reciprocals for division by small constants, with their shifts.
	localparam int unsigned Recip25 = 1311;   // x / 25 = (x * 1311) >> 15
	localparam int unsigned Recip225 = 4661;  // x / 225 = (x * 4661) >> 20
	localparam int unsigned Recip15 = 1093;   // x / 15 = (x * 1093) >> 14
	localparam int unsigned Recip7 = 9363;    // x / 7 = (x * 9363) >> 16

	localparam int unsigned CfgAddrW = 1;
	localparam int unsigned CfgDataW = 17;
	localparam logic [CfgAddrW-1:0] CFG_START_YEAR = 1'b0;
	localparam logic [CfgAddrW-1:0] CFG_ZONE_OFFSET = 1'b1;

	localparam int unsigned InDataW = 32;
	localparam int unsigned OutDataW = 48;

	typedef struct packed {
		logic load;
		logic div_mul;
		logic div_fix;
		logic walk_init;
		logic year_walk;
		logic month_walk;
		logic out_load;
	} escd_cmd_t;

	typedef struct packed {
		logic neg;
		logic year_fits;
		logic month_fits;
		logic out_free;
	} escd_sts_t;

	// Days in month by index 0..11, February taken as 28.
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd1: d = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	// (3 * (mm + 1)) / 5 for the weekday sum, mm from 3 to 14.
	function automatic logic [3:0] month_term(input logic [4:0] mm);
		logic [3:0] t;
		case (mm)
			5'd3: t = 4'd2;
			5'd4, 5'd5: t = 4'd3;
			5'd6, 5'd7: t = 4'd4;
			5'd8: t = 4'd5;
			5'd9, 5'd10: t = 4'd6;
			5'd11, 5'd12: t = 4'd7;
			5'd13: t = 4'd8;
			5'd14: t = 4'd9;
			default: t = 4'd0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/escd_ctrl.sv @@
// Sequencer of the epoch-to-calendar converter: divide, year walk, month walk, finish.
// Depends on escd_pkg for the command and status structs.
module escd_ctrl import escd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  escd_sts_t sts,
	output escd_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_MUL,
		ST_DIV_FIX,
		ST_INIT,
		ST_YEAR,
		ST_MONTH,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_FIN4
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_ready & in_valid;
		cmd.div_mul = (state_q == ST_DIV_MUL);
		cmd.div_fix = (state_q == ST_DIV_FIX);
		cmd.walk_init = (state_q == ST_INIT);
		cmd.year_walk = (state_q == ST_YEAR);
		cmd.month_walk = (state_q == ST_MONTH);
		cmd.out_load = (state_q == ST_FIN4) & sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DIV_MUL;
				ST_DIV_MUL: state_q <= ST_DIV_FIX;
				ST_DIV_FIX: begin
					// A negative local time is always the last day of the year before.
					state_q <= sts.neg ? ST_FIN1 : ST_INIT;
				end
				ST_INIT: state_q <= ST_YEAR;
				ST_YEAR: if (sts.year_fits) state_q <= ST_MONTH;
				ST_MONTH: if (sts.month_fits) state_q <= ST_FIN1;
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: state_q <= ST_FIN3;
				ST_FIN3: state_q <= ST_FIN4;
				ST_FIN4: if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/escd_dp.sv @@
// Datapath of the epoch-to-calendar converter: day divider, year and month walk,
// time-of-day and weekday arithmetic, output register. Depends on escd_pkg.
module escd_dp import escd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  escd_cmd_t            cmd,
	output escd_sts_t            sts,
	input  logic [11:0]          start_year,
	input  logic signed [16:0]   zone_offset_seconds,
	input  logic [InDataW-1:0]   unix_seconds,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OutDataW-1:0]  out_data
);

	// Load: exact local time, 34 bits signed.
	logic [33:0] total;
	logic        neg;
	logic [16:0] neg_sod;

	assign total = {2'b00, unix_seconds} + {{17{zone_offset_seconds[16]}}, zone_offset_seconds};
	assign neg = total[33];
	assign neg_sod = total[16:0] + 17'(SecsPerDay);

	// Day split; after the fix step num_q is the day count, rem_q the second of day.
	// The low seven bits pass straight into the remainder, the rest is divided by 675.
	logic [32:0] num_q;
	logic [16:0] rem_q;
	logic [51:0] prod_q;
	logic        neg_q;
	logic [15:0] quot;
	logic [9:0]  rem_hi;

	assign quot = prod_q[51:36];
	assign rem_hi = 10'(num_q[32:7] - 26'(quot) * 26'(DayOdd));

	// Calendar walk state.
	logic [12:0] by_q;
	logic [15:0] days_q;
	logic [3:0]  m_q;
	logic [4:0]  m25_q;
	logic [22:0] sy_prod_q;
	logic [11:0] sy_mod25;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	assign sy_mod25 = start_year - 12'(sy_prod_q[22:15]) * 12'd25;
	assign leap = (by_q[1:0] == 2'd0) && ((m25_q != 5'd0) || (by_q[3:0] == 4'd0));
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = (m_q == 4'd1 && leap) ? 5'd29 : month_days(m_q);

	always_comb begin
		sts.neg = neg_q;
		sts.year_fits = (days_q < 16'(ylen));
		sts.month_fits = (m_q == 4'd11) || (days_q < 16'(mlen));
		sts.out_free = !out_valid || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= neg ? {16'd0, neg_sod} : total[32:0];
			rem_q <= '0;
			neg_q <= neg;
			by_q <= {1'b0, start_year} + 13'(YearBias - 1);
			m_q <= 4'd11;
			days_q <= 16'd30;
			sy_prod_q <= 23'(start_year) * 23'(Recip25);
		end else if (cmd.div_mul) begin
			prod_q <= 52'(num_q[32:7]) * 52'(Recip675);
		end else if (cmd.div_fix) begin
			num_q <= {17'd0, quot};
			rem_q <= {rem_hi, num_q[6:0]};
		end else if (cmd.walk_init) begin
			by_q <= {1'b0, start_year} + 13'(YearBias);
			days_q <= num_q[15:0];
			m_q <= 4'd0;
			m25_q <= sy_mod25[4:0];
		end else if (cmd.year_walk) begin
			if (!sts.year_fits) begin
				days_q <= days_q - 16'(ylen);
				by_q <= by_q + 13'd1;
				m25_q <= (m25_q == 5'd24) ? 5'd0 : m25_q + 5'd1;
			end
		end else if (cmd.month_walk) begin
			if (!sts.month_fits) begin
				days_q <= days_q - 16'(mlen);
				m_q <= m_q + 4'd1;
			end
		end
	end

	// Finish pipeline; it runs freely, its sources hold still once the walk is over.
	logic        early;
	logic [12:0] wy;
	logic [4:0]  mm;

	assign early = (m_q < 4'd2);
	assign wy = early ? by_q - 13'd1 : by_q;
	assign mm = early ? 5'(m_q) + 5'd13 : 5'(m_q) + 5'd1;

	logic [12:0] wy_s1;
	logic [4:0]  mm_s1;
	logic [4:0]  day_s1;
	logic [21:0] p100_s1;
	logic [19:0] p400_s1;
	logic [25:0] phour_s1;

	always_ff @(posedge clk) begin
		wy_s1 <= wy;
		mm_s1 <= mm;
		day_s1 <= days_q[4:0] + 5'd1;
		p100_s1 <= 22'(wy[12:2]) * 22'(Recip25);
		p400_s1 <= 20'(wy[12:4]) * 20'(Recip25);
		phour_s1 <= 26'(rem_q[16:4]) * 26'(Recip225);
	end

	logic [4:0]  hour_s2;
	logic [11:0] sec_hr_s2;
	logic [13:0] wsum_s2;
	logic [16:0] hour_secs;

	assign hour_secs = 17'(phour_s1[24:20]) * 17'(SecsPerHour);

	always_ff @(posedge clk) begin
		hour_s2 <= phour_s1[24:20];
		sec_hr_s2 <= 12'(rem_q - hour_secs);
		wsum_s2 <= 14'(day_s1) + {8'd0, mm_s1, 1'b0} + 14'(month_term(mm_s1))
			+ 14'(wy_s1) + 14'(wy_s1[12:2]) - 14'(p100_s1[21:15]) + 14'(p400_s1[19:15]);
	end

	logic [4:0]  hour_s3;
	logic [11:0] sec_hr_s3;
	logic [13:0] wsum_s3;
	logic [20:0] pmin_s3;
	logic [27:0] pw_s3;

	always_ff @(posedge clk) begin
		hour_s3 <= hour_s2;
		sec_hr_s3 <= sec_hr_s2;
		wsum_s3 <= wsum_s2;
		pmin_s3 <= 21'(sec_hr_s2[11:2]) * 21'(Recip15);
		pw_s3 <= 28'(wsum_s2) * 28'(Recip7);
	end

	logic [5:0]  minute;
	logic [5:0]  second;
	logic [2:0]  weekday;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;

	assign minute = pmin_s3[19:14];
	assign second = 6'(sec_hr_s3 - 12'(minute) * 12'd60);
	assign weekday = 3'(wsum_s3 - 14'(pw_s3[27:16]) * 14'd7);
	assign year = 12'(by_q - 13'(YearBias));
	assign month = m_q + 4'd1;
	assign day = days_q[4:0] + 5'd1;

	// Output register.
	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {7'd0, weekday, second, minute, hour_s3, day, month, year};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

@@ rtl/epoch_seconds_to_calendar_date.sv @@
// Top level of the epoch-to-calendar converter: configuration registers and the
// controller and datapath instances. Depends on escd_pkg, escd_ctrl and escd_dp.
//
// channel   direction  signals                       contents
// s_axis    in         s_tvalid s_tready s_tdata     [31:0] unix_seconds
// m_axis    out        m_tvalid m_tready m_tdata     year, month, day, hour, minute,
//                                                    second, weekday (low bits first)
// config    in         cfg_we cfg_addr cfg_wdata     0 start_year, 1 zone_offset_seconds
//
// Between acceptance and a loaded result an item passes the day split, a walk over
// whole years (up to 136) and one over months (up to 11), and the finish states.
// A local time before day zero skips both walks.
// The year walk runs at one year per cycle; the day split is a reciprocal multiplication
// in a multiply step and a fix step. A new item is taken once the result is in the output
// register; a stalled output holds the finished item while the next one is converted.
// Reset sets start_year to 1970 and the zone offset to +28800 seconds.
module epoch_seconds_to_calendar_date import escd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // [31:0] unix_seconds
	output logic                m_tvalid,
	input  logic                m_tready,
	// [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] minute,
	// [37:32] second, [40:38] weekday, [47:41] zero
	output logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	logic [11:0]        start_year_q;
	logic signed [16:0] zone_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_year_q <= 12'd1970;
			zone_offset_q <= 17'sd28800;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_START_YEAR: start_year_q <= cfg_wdata[11:0];
				CFG_ZONE_OFFSET: zone_offset_q <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	escd_cmd_t cmd;
	escd_sts_t sts;

	escd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	escd_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.start_year          (start_year_q),
		.zone_offset_seconds (zone_offset_q),
		.unix_seconds        (s_tdata),
		.out_valid           (m_tvalid),
		.out_ready           (m_tready),
		.out_data            (m_tdata)
	);

endmodule
